// ===== sv/qkv_pkg.sv =====
// Shared types and constants of the quadrature knob volume block.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package qkv_pkg;

  localparam int unsigned VolumeWidth = 6;
  localparam int unsigned AddrWidth   = 3;
  localparam int unsigned DataWidth   = 32;

  localparam logic [VolumeWidth-1:0] VOLUME_MAX_RESET = 6'd63;
  localparam logic [VolumeWidth-1:0] VOLUME_ZERO      = 6'd0;
  localparam logic [VolumeWidth-1:0] VOLUME_ONE       = 6'd1;

  // Register index, taken from paddr[2]
  localparam logic REG_VOLUME_MAX = 1'b0;

  // Phase pairs, bit 1 = A, bit 0 = B
  localparam logic [1:0] PH_REST   = 2'b11;
  localparam logic [1:0] PH_B_ONLY = 2'b01;
  localparam logic [1:0] PH_A_ONLY = 2'b10;
  localparam logic [1:0] PH_NONE   = 2'b00;

  // Turn codes of a result
  localparam logic [1:0] TURN_NONE  = 2'd0;
  localparam logic [1:0] TURN_RIGHT = 2'd1;
  localparam logic [1:0] TURN_LEFT  = 2'd2;

  typedef enum logic [6:0] {
    S_REST = 7'b0000001,
    S_R1   = 7'b0000010,
    S_R2   = 7'b0000100,
    S_R3   = 7'b0001000,
    S_L1   = 7'b0010000,
    S_L2   = 7'b0100000,
    S_L3   = 7'b1000000
  } phase_state_t;

  typedef struct packed {
    logic right;
    logic left;
  } detent_t;

endpackage

`default_nettype wire

// ===== sv/quadrature_knob_volume_top.sv =====
// Top level of the quadrature knob volume block: sample pipe, register port, assertions.
// Depends on qkv_pkg, qkv_phase_fsm and qkv_volume.
`default_nettype none

// Quadrature knob volume control. Each request on the sample channel carries one
// pin sample of a rotary knob (phase_ab: bit 1 = A, bit 0 = B, both high at rest;
// knob_pressed) and yields exactly one request on the result channel with the
// new volume, a changed flag and the turn code (0 none, 1 right, 2 left). A
// detent counts only when a full phase cycle returns to rest; the volume
// saturates at 0 and at the volume_max register (byte address 0, reset 63).
// A press clears the volume before the same sample's detent is applied.
// Rate: one sample per clock, sustained while result_stall is low. A sample
// lands in an input register, and the phase machine plus counter update sit
// between that register and the result register, where the result waits
// until the result channel takes it.
// The result register frees the input side: a new sample is taken while a
// finished result still waits, and result_stall reaches sample_stall only when
// both registers are full. Write volume_max only while no sample is in flight.
module quadrature_knob_volume_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // register port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [qkv_pkg::AddrWidth-1:0]       paddr,
  input  wire logic [qkv_pkg::DataWidth-1:0]       pwdata,
  output logic      [qkv_pkg::DataWidth-1:0]       prdata,
  output logic                                     pready,
  // sample channel
  input  wire logic                                sample_valid,
  output logic                                     sample_stall,
  input  wire logic [1:0]                          phase_ab,
  input  wire logic                                knob_pressed,
  // result channel
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output logic      [qkv_pkg::VolumeWidth-1:0]     volume,
  output logic                                     changed,
  output logic      [1:0]                          turn
);

  // ---- register port ----
  logic [qkv_pkg::VolumeWidth-1:0] volume_max;
  logic                            reg_index;
  logic                            reg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];
  assign reg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_max <= qkv_pkg::VOLUME_MAX_RESET;
    end else if (reg_write && (reg_index == qkv_pkg::REG_VOLUME_MAX)) begin
      volume_max <= pwdata[qkv_pkg::VolumeWidth-1:0];
    end
  end

  // Read back the limit; anything beyond the register list reads zero
  always_comb begin
    prdata = '0;
    if (reg_index == qkv_pkg::REG_VOLUME_MAX) begin
      prdata = {{(qkv_pkg::DataWidth-qkv_pkg::VolumeWidth){1'b0}}, volume_max};
    end
  end

  // ---- input register ----
  logic       s1_valid;
  logic [1:0] s1_phase_ab;
  logic       s1_pressed;
  logic       result_free;
  logic       s1_advance;
  logic       sample_take;

  // The result slot takes a new request when empty or when its request leaves now
  assign result_free  = ~result_valid | ~result_stall;
  assign s1_advance   = s1_valid & result_free;
  assign sample_stall = s1_valid & ~result_free;
  assign sample_take  = sample_valid & ~sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_take) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Hold the payload while stalled; load only on acceptance
  always_ff @(posedge clk) begin
    if (sample_take) begin
      s1_phase_ab <= phase_ab;
      s1_pressed  <= knob_pressed;
    end
  end

  // ---- step logic ----
  qkv_pkg::detent_t                detent;
  logic [qkv_pkg::VolumeWidth-1:0] volume_next;
  logic                            changed_next;
  logic [1:0]                      turn_next;

  qkv_phase_fsm u_phase_fsm (
    .clk      (clk),
    .rst      (rst),
    .advance  (s1_advance),
    .phase_ab (s1_phase_ab),
    .detent   (detent)
  );

  qkv_volume u_volume (
    .clk         (clk),
    .rst         (rst),
    .advance     (s1_advance),
    .pressed     (s1_pressed),
    .detent      (detent),
    .volume_max  (volume_max),
    .volume_next (volume_next),
    .changed     (changed_next)
  );

  always_comb begin
    if (detent.right) begin
      turn_next = qkv_pkg::TURN_RIGHT;
    end else if (detent.left) begin
      turn_next = qkv_pkg::TURN_LEFT;
    end else begin
      turn_next = qkv_pkg::TURN_NONE;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      volume  <= volume_next;
      changed <= changed_next;
      turn    <= turn_next;
    end
  end

`ifndef NO_ASSERTIONS
  // A waiting sample moves into an empty result slot on the next edge
  a_fill_result: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !result_valid) |=> result_valid)
    else $error("waiting sample did not reach empty result slot");

  // Every completed detent is reported as a change
  a_turn_changed: assert property (@(posedge clk) disable iff (rst)
    (result_valid && turn != qkv_pkg::TURN_NONE) |-> changed)
    else $error("detent reported without change flag");

  // A press clears the volume, so at most one detent step remains
  a_press_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_pressed) |=> (changed && volume <= qkv_pkg::VOLUME_ONE))
    else $error("press did not clear the volume");
`endif

endmodule

`default_nettype wire

// ===== sv/qkv_phase_fsm.sv =====
// Phase sequence tracker: seven-state one-hot machine, one detent per full cycle.
// Depends on qkv_pkg.
`default_nettype none

module qkv_phase_fsm (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire logic [1:0]      phase_ab,
  output qkv_pkg::detent_t     detent
);

  qkv_pkg::phase_state_t phase_state, phase_state_next;

  always_comb begin
    phase_state_next = phase_state;
    detent = '0;
    case (phase_state)
      qkv_pkg::S_REST: begin
        if (phase_ab == qkv_pkg::PH_B_ONLY) phase_state_next = qkv_pkg::S_R1;
        else if (phase_ab == qkv_pkg::PH_A_ONLY) phase_state_next = qkv_pkg::S_L1;
      end
      qkv_pkg::S_R1: begin
        if (phase_ab == qkv_pkg::PH_REST) phase_state_next = qkv_pkg::S_REST;
        else if (phase_ab == qkv_pkg::PH_NONE) phase_state_next = qkv_pkg::S_R2;
      end
      qkv_pkg::S_R2: begin
        if (phase_ab == qkv_pkg::PH_B_ONLY) phase_state_next = qkv_pkg::S_R1;
        else if (phase_ab == qkv_pkg::PH_A_ONLY) phase_state_next = qkv_pkg::S_R3;
      end
      qkv_pkg::S_R3: begin
        if (phase_ab == qkv_pkg::PH_REST) begin
          phase_state_next = qkv_pkg::S_REST;
          detent.right = 1'b1;
        end else if (phase_ab == qkv_pkg::PH_NONE) begin
          phase_state_next = qkv_pkg::S_R2;
        end
      end
      qkv_pkg::S_L1: begin
        if (phase_ab == qkv_pkg::PH_NONE) phase_state_next = qkv_pkg::S_L2;
        else if (phase_ab == qkv_pkg::PH_REST) phase_state_next = qkv_pkg::S_REST;
      end
      qkv_pkg::S_L2: begin
        if (phase_ab == qkv_pkg::PH_B_ONLY) phase_state_next = qkv_pkg::S_L3;
        else if (phase_ab == qkv_pkg::PH_A_ONLY) phase_state_next = qkv_pkg::S_L1;
      end
      qkv_pkg::S_L3: begin
        if (phase_ab == qkv_pkg::PH_REST) begin
          phase_state_next = qkv_pkg::S_REST;
          detent.left = 1'b1;
        end else if (phase_ab == qkv_pkg::PH_NONE) begin
          phase_state_next = qkv_pkg::S_L2;
        end
      end
      default: begin
        phase_state_next = phase_state;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_state <= qkv_pkg::S_REST;
    end else if (advance) begin
      phase_state <= phase_state_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/qkv_volume.sv =====
// Saturating volume counter: clear on press, then step by the detent.
// Depends on qkv_pkg.
`default_nettype none

module qkv_volume (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              advance,
  input  wire logic                              pressed,
  input  wire qkv_pkg::detent_t                  detent,
  input  wire logic [qkv_pkg::VolumeWidth-1:0]   volume_max,
  output logic      [qkv_pkg::VolumeWidth-1:0]   volume_next,
  output logic                                   changed
);

  logic [qkv_pkg::VolumeWidth-1:0] volume_count;
  logic [qkv_pkg::VolumeWidth-1:0] base;

  always_comb begin
    base = pressed ? qkv_pkg::VOLUME_ZERO : volume_count;
    volume_next = base;
    if (detent.right && (base < volume_max)) begin
      volume_next = base + qkv_pkg::VOLUME_ONE;
    end else if (detent.left && (base != qkv_pkg::VOLUME_ZERO)) begin
      volume_next = base - qkv_pkg::VOLUME_ONE;
    end
    changed = pressed | detent.right | detent.left;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_count <= qkv_pkg::VOLUME_ZERO;
    end else if (advance) begin
      volume_count <= volume_next;
    end
  end

endmodule

`default_nettype wire
